// ----- sv/clcd_pkg.sv -----
`timescale 1ns / 1ps

package clcd_pkg;

   // Host operation carried in the request tuser field.
   typedef enum logic [1:0] {
      OP_COMMAND    = 2'd0,
      OP_DATA       = 2'd1,
      OP_READ_CELL  = 2'd2,
      OP_READ_GLYPH = 2'd3
   } op_type;

   // Command byte patterns, tested in priority order.
   localparam logic [7:0] CMD_FUNC_MASK   = 8'hE0;
   localparam logic [7:0] CMD_FUNC_CODE   = 8'h20;
   localparam logic [7:0] CMD_DISP_MASK   = 8'hF8;
   localparam logic [7:0] CMD_DISP_CODE   = 8'h08;
   localparam logic [7:0] CMD_CLEAR       = 8'h01;
   localparam logic [7:0] CMD_HOME        = 8'h02;
   localparam logic [7:0] CMD_ENTRY_MASK  = 8'hFC;
   localparam logic [7:0] CMD_ENTRY_CODE  = 8'h04;
   localparam logic [7:0] CMD_CGADDR_MASK = 8'hC0;
   localparam logic [7:0] CMD_CGADDR_CODE = 8'h40;
   localparam logic [7:0] CMD_DDADDR_MASK = 8'h80;
   localparam logic [7:0] CMD_DDADDR_CODE = 8'h80;

   localparam logic [7:0] SPACE_CHAR = 8'h20;

   localparam int GLYPH_ROWS   = 64;
   localparam int GLYPH_BITS   = 5;
   localparam int GLYPH_AWIDTH = 6;

   // Mode flag byte, bit 7 down to bit 0.
   typedef struct packed {
      logic wide_bus;
      logic two_line;
      logic large_font;
      logic display_on;
      logic cursor_on;
      logic blink_on;
      logic increment;
      logic shift_on;
   } mode_type;

   // Controller state as reported with every result.
   typedef struct packed {
      logic [6:0] dd_address;
      logic [5:0] cg_address;
      logic       ram_select;
      mode_type   mode;
   } status_type;

   // Memory accesses requested by the command and data decoder.
   typedef struct packed {
      logic       disp_we;
      logic       glyph_we;
      logic       clear;
      logic [6:0] disp_idx;
      logic [5:0] glyph_idx;
      logic [7:0] wdata;
   } mem_req_type;

endpackage

// ----- sv/char_lcd_controller_unit.sv -----
`timescale 1ns / 1ps

// Character LCD controller register interface. Each request transfer carries one host
// operation (command write, data write, display cell read or glyph row read) and
// produces exactly one response transfer holding the read data and the controller
// state after that operation. The block takes one request per clock cycle while the
// response channel does not hold it back; each response passes through the registered
// read port of the display and glyph memories and then the response register. Both
// memories come up in their reset contents at once after reset, and the clear command
// empties every display cell at once, so the block never pauses for a fill pass.
module char_lcd_controller_unit #(
   parameter int DISPLAY_CELLS = 80,
   parameter int LINE_CELLS    = 40
) (
   input  logic        clock,
   input  logic        reset,
   // Request channel.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,  // value[7:0], cell_index[14:8], glyph_index[20:15], zero
   input  logic [1:0]  req_tuser,  // op[1:0]
   // Response channel.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata   // read_data[7:0], dd_address[14:8], cg_address[20:15],
                                   // ram_select[21], two_line[22], increment[23],
                                   // display_on[24], cursor_on[25], blink_on[26],
                                   // wide_bus[27], large_font[28], shift_on[29], zero
);

   localparam int DISP_AW = $clog2(DISPLAY_CELLS);

   // Request fields.
   clcd_pkg::op_type req_op;
   logic [7:0]       req_value;
   logic [6:0]       req_cell;
   logic [5:0]       req_glyph;
   logic             req_accept;

   assign req_op    = clcd_pkg::op_type'(req_tuser);
   assign req_value = req_tdata[7:0];
   assign req_cell  = req_tdata[14:8];
   assign req_glyph = req_tdata[20:15];

   // Decoder and state registers.
   clcd_pkg::status_type  status_next;
   clcd_pkg::mem_req_type mem_req;

   clcd_decode #(
      .DISPLAY_CELLS(DISPLAY_CELLS),
      .LINE_CELLS   (LINE_CELLS)
   ) u_decode (
      .clock      (clock),
      .reset      (reset),
      .accept     (req_accept),
      .op         (req_op),
      .value      (req_value),
      .status_next(status_next),
      .mem_req    (mem_req)
   );

   // Display and glyph memories. A cleared valid bit makes an entry read as its reset
   // contents: a space for display cells, zero for glyph rows.
   logic [7:0]                       disp_rdata;
   logic [clcd_pkg::GLYPH_BITS-1:0]  glyph_rdata;
   logic [DISPLAY_CELLS-1:0]         disp_valid_ff;
   logic [clcd_pkg::GLYPH_ROWS-1:0]  glyph_valid_ff;

   clcd_ram #(
      .WIDTH(8),
      .DEPTH(DISPLAY_CELLS)
   ) u_disp_ram (
      .clock(clock),
      .we   (mem_req.disp_we),
      .waddr(mem_req.disp_idx[DISP_AW-1:0]),
      .wdata(mem_req.wdata),
      .re   (req_accept),
      .raddr(req_cell[DISP_AW-1:0]),
      .rdata(disp_rdata)
   );

   clcd_ram #(
      .WIDTH(clcd_pkg::GLYPH_BITS),
      .DEPTH(clcd_pkg::GLYPH_ROWS)
   ) u_glyph_ram (
      .clock(clock),
      .we   (mem_req.glyph_we),
      .waddr(mem_req.glyph_idx),
      .wdata(mem_req.wdata[clcd_pkg::GLYPH_BITS-1:0]),
      .re   (req_accept),
      .raddr(req_glyph),
      .rdata(glyph_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         disp_valid_ff  <= '0;
         glyph_valid_ff <= '0;
      end else begin
         if (mem_req.clear) begin
            disp_valid_ff <= '0;
         end else if (mem_req.disp_we) begin
            disp_valid_ff[mem_req.disp_idx[DISP_AW-1:0]] <= 1'b1;
         end
         if (mem_req.glyph_we) begin
            glyph_valid_ff[mem_req.glyph_idx] <= 1'b1;
         end
      end
   end

   // Stage one: waits for the memory read data alongside the state snapshot.
   logic                 s1_valid_ff;
   clcd_pkg::op_type     s1_op_ff;
   logic                 s1_cell_ok_ff;
   logic                 s1_entry_valid_ff;
   clcd_pkg::status_type s1_status_ff;
   logic                 req_cell_ok;
   logic                 req_entry_valid;
   logic                 out_take;

   assign req_cell_ok = {1'b0, req_cell} < 8'(DISPLAY_CELLS);

   always_comb begin
      if (req_op == clcd_pkg::OP_READ_GLYPH) begin
         req_entry_valid = glyph_valid_ff[req_glyph];
      end else if (req_cell_ok) begin
         req_entry_valid = disp_valid_ff[req_cell[DISP_AW-1:0]];
      end else begin
         req_entry_valid = 1'b0;
      end
   end

   // The response register can load when it is empty or its transfer completes now.
   assign out_take   = !rsp_tvalid || rsp_tready;
   assign req_tready = !s1_valid_ff || out_take;
   assign req_accept = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_tready) begin
         s1_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_op_ff          <= req_op;
         s1_cell_ok_ff     <= req_cell_ok;
         s1_entry_valid_ff <= req_entry_valid;
         s1_status_ff      <= status_next;
      end
   end

   // Read data selection.
   logic [7:0] read_data;

   always_comb begin
      case (s1_op_ff)
         clcd_pkg::OP_READ_CELL: begin
            if (!s1_cell_ok_ff) begin
               read_data = 8'd0;
            end else if (s1_entry_valid_ff) begin
               read_data = disp_rdata;
            end else begin
               read_data = clcd_pkg::SPACE_CHAR;
            end
         end
         clcd_pkg::OP_READ_GLYPH: begin
            read_data = s1_entry_valid_ff ?
                        {{(8 - clcd_pkg::GLYPH_BITS){1'b0}}, glyph_rdata} : 8'd0;
         end
         default: begin
            read_data = 8'd0;
         end
      endcase
   end

   // Response register.
   logic        rsp_valid_ff;
   logic [31:0] rsp_data_ff;
   logic        out_load;

   assign out_load = s1_valid_ff && out_take;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_take) begin
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_data_ff <= {2'b00,
                         s1_status_ff.mode.shift_on,
                         s1_status_ff.mode.large_font,
                         s1_status_ff.mode.wide_bus,
                         s1_status_ff.mode.blink_on,
                         s1_status_ff.mode.cursor_on,
                         s1_status_ff.mode.display_on,
                         s1_status_ff.mode.increment,
                         s1_status_ff.mode.two_line,
                         s1_status_ff.ram_select,
                         s1_status_ff.cg_address,
                         s1_status_ff.dd_address,
                         read_data};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

`ifndef SYNTH
   // An accepted request always occupies stage one in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      req_accept |=> s1_valid_ff)
      else $error("accepted request did not reach stage one");

   // A blocked stage one keeps its item and its snapshot.
   assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !out_take |=> s1_valid_ff && $stable(s1_status_ff))
      else $error("stage one lost or changed a waiting item");

   // A clear command empties every display cell at once.
   assert property (@(posedge clock) disable iff (reset)
      req_accept && req_op == clcd_pkg::OP_COMMAND && req_value == clcd_pkg::CMD_CLEAR
      |=> disp_valid_ff == '0)
      else $error("clear did not reset the display valid bits");

   // Write operations report zero read data.
   assert property (@(posedge clock) disable iff (reset)
      out_load && (s1_op_ff == clcd_pkg::OP_COMMAND || s1_op_ff == clcd_pkg::OP_DATA)
      |=> rsp_tdata[7:0] == 8'd0)
      else $error("write response carries read data");
`endif

endmodule

// ----- sv/clcd_ram.sv -----
`timescale 1ns / 1ps

module clcd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 80
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ----- sv/clcd_decode.sv -----
`timescale 1ns / 1ps

module clcd_decode #(
   parameter int DISPLAY_CELLS = 80,
   parameter int LINE_CELLS    = 40
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 accept,
   input  clcd_pkg::op_type     op,
   input  logic [7:0]           value,
   output clcd_pkg::status_type status_next,
   output clcd_pkg::mem_req_type mem_req
);

   clcd_pkg::status_type status_ff;
   clcd_pkg::status_type status_in;
   clcd_pkg::mem_req_type req_in;

   logic [7:0] col;
   logic [7:0] line_base;
   logic [7:0] cell_idx;
   logic       cell_ok;

   // Display cell that the current address counter points at.
   always_comb begin
      if (status_ff.mode.two_line) begin
         col       = {2'b00, status_ff.dd_address[5:0]};
         line_base = status_ff.dd_address[6] ? 8'(LINE_CELLS) : 8'd0;
         cell_idx  = col + line_base;
         cell_ok   = (col < 8'(LINE_CELLS)) && (cell_idx < 8'(DISPLAY_CELLS));
      end else begin
         col       = {1'b0, status_ff.dd_address};
         line_base = 8'd0;
         cell_idx  = col;
         cell_ok   = cell_idx < 8'(DISPLAY_CELLS);
      end
   end

   always_comb begin
      status_in        = status_ff;
      req_in           = '0;
      req_in.disp_idx  = cell_idx[6:0];
      req_in.glyph_idx = status_ff.cg_address;
      req_in.wdata     = value;
      if (accept) begin
         case (op)
            clcd_pkg::OP_COMMAND: begin
               if ((value & clcd_pkg::CMD_FUNC_MASK) == clcd_pkg::CMD_FUNC_CODE) begin
                  status_in.mode.wide_bus   = value[4];
                  status_in.mode.two_line   = value[3];
                  status_in.mode.large_font = value[2];
               end else if ((value & clcd_pkg::CMD_DISP_MASK) == clcd_pkg::CMD_DISP_CODE) begin
                  status_in.mode.display_on = value[2];
                  status_in.mode.cursor_on  = value[1];
                  status_in.mode.blink_on   = value[0];
               end else if (value == clcd_pkg::CMD_CLEAR) begin
                  status_in.dd_address     = '0;
                  status_in.mode.increment = 1'b1;
                  req_in.clear             = 1'b1;
               end else if (value == clcd_pkg::CMD_HOME) begin
                  status_in.dd_address = '0;
               end else if ((value & clcd_pkg::CMD_ENTRY_MASK) == clcd_pkg::CMD_ENTRY_CODE) begin
                  status_in.mode.increment = value[1];
                  status_in.mode.shift_on  = value[0];
               end else if ((value & clcd_pkg::CMD_CGADDR_MASK) ==
                            clcd_pkg::CMD_CGADDR_CODE) begin
                  status_in.cg_address = value[5:0];
                  status_in.ram_select = 1'b0;
               end else if ((value & clcd_pkg::CMD_DDADDR_MASK) ==
                            clcd_pkg::CMD_DDADDR_CODE) begin
                  status_in.dd_address = value[6:0];
                  status_in.ram_select = 1'b1;
               end
            end
            clcd_pkg::OP_DATA: begin
               if (!status_ff.ram_select) begin
                  req_in.glyph_we      = 1'b1;
                  status_in.cg_address = status_ff.mode.increment ?
                                         status_ff.cg_address + 6'd1 :
                                         status_ff.cg_address - 6'd1;
               end else begin
                  req_in.disp_we       = cell_ok;
                  status_in.dd_address = status_ff.mode.increment ?
                                         status_ff.dd_address + 7'd1 :
                                         status_ff.dd_address - 7'd1;
               end
            end
            default: begin
               // Reads leave the state alone.
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         status_ff <= '0;
      end else begin
         status_ff <= status_in;
      end
   end

   assign status_next = status_in;
   assign mem_req     = req_in;

endmodule
